[hdl/rer_pkg.sv]
// shared types and constants of the rtt estimator and timeout block
package rer_pkg;

  localparam int FlowCount  = 16;
  localparam int FlowW      = 4;
  localparam int FlowCntW   = FlowW + 1;
  localparam int DataW      = 24;
  localparam int CfgIdxW    = 2;
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = 1;
  localparam int QueueCntW  = 2;

  localparam logic [DataW-1:0] MinTimeoutRst     = DataW'(1000);
  localparam logic [DataW-1:0] MaxTimeoutRst     = DataW'(60000);
  localparam logic [DataW-1:0] InitialTimeoutRst = DataW'(1000);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MIN_TIMEOUT     = 2'd0,
    CFG_MAX_TIMEOUT     = 2'd1,
    CFG_INITIAL_TIMEOUT = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    ACT_SAMPLE = 1'b0,
    ACT_RESET  = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    OP_SAMPLE,
    OP_RESET,
    OP_IGNORE
  } op_e;

  typedef enum logic [1:0] {
    ST_FETCH,
    ST_CALC,
    ST_DONE
  } back_state_e;

  typedef struct packed {
    op_e              op;
    logic [FlowW-1:0] flow;
    logic [DataW-1:0] sample;
  } job_t;

  typedef struct packed {
    logic [DataW-1:0] min_timeout;
    logic [DataW-1:0] max_timeout;
    logic [DataW-1:0] initial_timeout;
  } cfg_t;

endpackage

[hdl/rer_in_if.sv]
// input channel: one rtt sample or flow reset per transfer
interface rer_in_if;
  import rer_pkg::*;

  logic             valid;
  logic             ready;
  logic             action;
  logic [FlowW-1:0] flow_index;
  logic [DataW-1:0] meas_rtt;

  modport source (output valid, output action, output flow_index, output meas_rtt,
                  input ready);
  modport sink   (input valid, input action, input flow_index, input meas_rtt,
                  output ready);
endinterface

[hdl/rer_out_if.sv]
// output channel: updated timeout and estimator values per transfer
interface rer_out_if;
  import rer_pkg::*;

  logic             valid;
  logic             ready;
  logic [DataW-1:0] rto_val;
  logic [DataW-1:0] smoothed_rtt;
  logic [DataW-1:0] rtt_variation;

  modport source (output valid, output rto_val, output smoothed_rtt,
                  output rtt_variation, input ready);
  modport sink   (input valid, input rto_val, input smoothed_rtt,
                  input rtt_variation, output ready);
endinterface

[hdl/rer_front.sv]
// front end: accepts items, classifies them and queues them for the back end
module rer_front
  import rer_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  rer_in_if.sink in_ch,
  output logic  job_valid_o,
  output job_t  job_o,
  input  logic  job_pop_i
);

  job_t                 queue_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] count_q, count_d;
  logic                 push, pop;
  job_t                 job_in;

  assign in_ch.ready = (count_q != QueueCntW'(QueueDepth));
  assign push        = in_ch.valid && in_ch.ready;
  assign pop         = job_pop_i && (count_q != '0);

  always_comb begin
    job_in.flow   = in_ch.flow_index;
    job_in.sample = (in_ch.meas_rtt == '0) ? DataW'(1) : in_ch.meas_rtt;
    if ({1'b0, in_ch.flow_index} >= FlowCntW'(FlowCount)) begin
      job_in.op = OP_IGNORE;
    end else if (action_e'(in_ch.action) == ACT_RESET) begin
      job_in.op = OP_RESET;
    end else begin
      job_in.op = OP_SAMPLE;
    end
  end

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + QueuePtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + QueuePtrW'(1) : rd_ptr_q;
    count_d  = count_q + QueueCntW'(push) - QueueCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= job_in;
    end
  end

  assign job_valid_o = (count_q != '0);
  assign job_o       = queue_q[rd_ptr_q];

endmodule

[hdl/rer_back.sv]
// back end: per-flow estimator state, update arithmetic and output register
module rer_back
  import rer_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  job_valid_i,
  input  job_t  job_i,
  output logic  job_pop_o,
  rer_out_if.source out_ch
);

  back_state_e state_q, state_d;

  logic [DataW-1:0] srtt_store_q   [FlowCount];
  logic [DataW-1:0] rttvar_store_q [FlowCount];
  logic [FlowCount-1:0] valid_marks_q;

  job_t             job_q;
  logic             was_valid_q;
  logic [DataW-1:0] old_s_q, old_v_q;
  logic [DataW-1:0] new_s_q, new_v_q;
  logic [DataW-1:0] new_s_d, new_v_d;

  logic [DataW-1:0] diff;
  logic [DataW+2:0] var_sum;
  logic [DataW+3:0] srtt_sum;
  logic [DataW+2:0] rto_wide;
  logic [DataW-1:0] rto;

  logic             out_valid_q;
  logic [DataW-1:0] out_timeout_q, out_srtt_q, out_var_q;

  logic fetch, finish, out_free;

  assign out_free = !out_valid_q || out_ch.ready;

  always_comb begin
    state_d = state_q;
    fetch   = 1'b0;
    finish  = 1'b0;
    case (state_q)
      ST_FETCH: begin
        if (job_valid_i) begin
          fetch   = 1'b1;
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          finish  = 1'b1;
          state_d = ST_FETCH;
        end
      end
      default: begin
        state_d = ST_FETCH;
      end
    endcase
  end

  assign job_pop_o = fetch;

  // estimator update
  always_comb begin
    diff     = (old_s_q > job_q.sample) ? old_s_q - job_q.sample : job_q.sample - old_s_q;
    var_sum  = (DataW+3)'({old_v_q, 1'b0}) + (DataW+3)'(old_v_q) + (DataW+3)'(diff);
    srtt_sum = (DataW+4)'({old_s_q, 3'b000}) - (DataW+4)'(old_s_q) + (DataW+4)'(job_q.sample);
    case (job_q.op)
      OP_SAMPLE: begin
        if (was_valid_q) begin
          new_s_d = srtt_sum[DataW+2:3];
          new_v_d = var_sum[DataW+1:2];
        end else begin
          new_s_d = job_q.sample;
          new_v_d = {1'b0, job_q.sample[DataW-1:1]};
        end
      end
      default: begin
        new_s_d = '0;
        new_v_d = '0;
      end
    endcase
  end

  // timeout with clamps, raise first then cut
  always_comb begin
    rto_wide = (DataW+3)'(new_s_q) + {1'b0, new_v_q, 2'b00};
    if (rto_wide < (DataW+3)'(cfg_i.min_timeout)) begin
      rto_wide = (DataW+3)'(cfg_i.min_timeout);
    end
    if (rto_wide > (DataW+3)'(cfg_i.max_timeout)) begin
      rto_wide = (DataW+3)'(cfg_i.max_timeout);
    end
    case (job_q.op)
      OP_SAMPLE: rto = rto_wide[DataW-1:0];
      OP_RESET:  rto = cfg_i.initial_timeout;
      default:   rto = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_FETCH;
      valid_marks_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (finish) begin
        out_valid_q <= 1'b1;
        if (job_q.op == OP_SAMPLE) begin
          valid_marks_q[job_q.flow] <= 1'b1;
        end else if (job_q.op == OP_RESET) begin
          valid_marks_q[job_q.flow] <= 1'b0;
        end
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fetch) begin
      job_q       <= job_i;
      was_valid_q <= valid_marks_q[job_i.flow];
      old_s_q     <= srtt_store_q[job_i.flow];
      old_v_q     <= rttvar_store_q[job_i.flow];
    end
    if (state_q == ST_CALC) begin
      new_s_q <= new_s_d;
      new_v_q <= new_v_d;
    end
    if (finish) begin
      out_timeout_q <= rto;
      out_srtt_q    <= new_s_q;
      out_var_q     <= new_v_q;
      if (job_q.op != OP_IGNORE) begin
        srtt_store_q[job_q.flow]   <= new_s_q;
        rttvar_store_q[job_q.flow] <= new_v_q;
      end
    end
  end

  assign out_ch.valid         = out_valid_q;
  assign out_ch.rto_val       = out_timeout_q;
  assign out_ch.smoothed_rtt  = out_srtt_q;
  assign out_ch.rtt_variation = out_var_q;

endmodule

[hdl/rtt_estimator_rto_top.sv]
// top level of the per-flow rtt estimator with retransmission timeout
//
// in_ch carries one item per transfer: an action (rtt sample or flow
// reset), a flow index and a sample in ms. out_ch returns exactly one
// result per item, in order: the new timeout, smoothed rtt and variation.
// The front end takes items into a two-entry queue while the back end
// works, so in_ch stays ready until the queue is full.
// The back end handles one item at a time: fetch of the flow state,
// estimator update, timeout clamp and write-back. It takes the next item
// from the queue only after the last one went to the output register.
// A result waits in the output register while out_ch is stalled; the
// back end then holds its finished item and the queue fills behind it.
// Reset empties the queue, drops the output, clears every flow's valid
// mark and loads the timeout limits with their defaults. The cfg port
// writes min, max and initial timeout by index; the user must do so only
// while the block is idle, as the block itself does not enforce this.
module rtt_estimator_rto_top
  import rer_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [DataW-1:0]   cfg_data_i,
  rer_in_if.sink             in_ch,
  rer_out_if.source          out_ch
);

  cfg_t cfg_q;
  logic job_valid, job_pop;
  job_t job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_timeout     <= MinTimeoutRst;
      cfg_q.max_timeout     <= MaxTimeoutRst;
      cfg_q.initial_timeout <= InitialTimeoutRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MIN_TIMEOUT:     cfg_q.min_timeout     <= cfg_data_i;
        CFG_MAX_TIMEOUT:     cfg_q.max_timeout     <= cfg_data_i;
        CFG_INITIAL_TIMEOUT: cfg_q.initial_timeout <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rer_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_pop_i   (job_pop)
  );

  rer_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_pop_o   (job_pop),
    .out_ch      (out_ch)
  );

endmodule
